// ----- design/lrcf_pkg.sv -----
// ----------------------------------------------------------------------------
// lrcf_pkg: shared types and constants of the log record CRC framer
// Item structs, queue entry format, status codes and the CRC-32C byte step.
// ----------------------------------------------------------------------------
package lrcf_pkg;

	// record geometry
	localparam int HEADER_BYTES = 24;
	localparam int PAD_ALIGN    = 8;
	localparam int SLOT_BYTES   = 4;
	localparam int LEN_W        = 21;
	localparam int PAD_W        = $clog2(PAD_ALIGN);

	localparam logic [LEN_W-1:0] PAYLOAD_CAP = LEN_W'(1048576);
	localparam logic [LEN_W-1:0] MAX_PAYLOAD_RST = LEN_W'(65536);
	localparam logic [LEN_W-1:0] HDR_LEN = LEN_W'(HEADER_BYTES);
	localparam logic [LEN_W-1:0] ALIGN_M1 = LEN_W'(PAD_ALIGN - 1);

	// CRC-32C, reflected
	localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;
	localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

	// status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BAD_LEN  = 2'd1;
	localparam logic [1:0] ST_SHORT    = 2'd2;
	localparam logic [1:0] ST_MISMATCH = 2'd3;

	// register map
	localparam int          ADDR_W          = 3;
	localparam logic        REG_MAX_PAYLOAD = 1'b0;

	// command queue
	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = $clog2(Q_DEPTH);

	typedef struct packed {
		logic        req_type;
		logic [7:0]  data_byte;
		logic        first_byte;
		logic        last_byte;
		logic [31:0] body_len;
		logic [30:0] space_bytes;
	} in_item_t;

	typedef struct packed {
		logic [7:0]       out_byte;
		logic             byte_valid;
		logic             done_res;
		logic [1:0]       status;
		logic [LEN_W-1:0] record_bytes;
		logic [31:0]      crc_value;
	} out_item_t;

	// one classified item, handed from front to back
	typedef struct packed {
		logic             init;       // restart CRC before this byte
		logic             has_byte;   // byte step present
		logic             crc_en;     // byte enters the CRC
		logic             emit;       // byte goes out as a result
		logic [7:0]       data;
		logic [PAD_W-1:0] pad_cnt;    // zero pad bytes after the byte
		logic             has_sum;    // closing summary follows
		logic             sum_calc;   // summary carries the CRC
		logic             sum_verify; // compare CRC with stored word
		logic [1:0]       sum_status; // status of a summary without CRC
		logic [LEN_W-1:0] rec_bytes;
		logic [31:0]      stored_crc;
	} cmd_t;

	// one byte of CRC-32C update
	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// ----- design/lrcf_queue.sv -----
// ----------------------------------------------------------------------------
// lrcf_queue: short command queue between front and back
// Register-based FIFO; head entry is visible while not empty.
// ----------------------------------------------------------------------------
module lrcf_queue import lrcf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_data,
	input  logic pop,
	output cmd_t head,
	output logic empty,
	output logic full
);

	cmd_t            mem_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_ptr_q;
	logic [Q_AW-1:0] rd_ptr_q;
	logic [Q_AW:0]   count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == (Q_AW+1)'(Q_DEPTH));
	assign head  = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- design/lrcf_front.sv -----
// ----------------------------------------------------------------------------
// lrcf_front: record tracking and item classification
// Checks length and space on the first byte, tracks the byte offset and
// the stored checksum word, and queues one command per item with work.
// ----------------------------------------------------------------------------
module lrcf_front import lrcf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [LEN_W-1:0] max_payload,
	input  logic             req_valid,
	output logic             req_stall,
	input  in_item_t         req,
	output logic             push,
	output cmd_t             push_data,
	input  logic             q_full
);

	logic             busy_q;
	logic             verify_q;
	logic [LEN_W-1:0] pos_q;
	logic [LEN_W-1:0] total_q;
	logic [LEN_W-1:0] cend_q;
	logic [31:0]      stored_q;

	logic             accept;
	logic [LEN_W-1:0] lim;
	logic             bad_len;
	logic [LEN_W-1:0] tot_new;
	logic [LEN_W-1:0] cend_new;
	logic             short_buf;
	logic             busy_e;
	logic             verify_e;
	logic [LEN_W-1:0] pos_e;
	logic [LEN_W-1:0] total_e;
	logic [LEN_W-1:0] cend_e;
	logic [31:0]      stored_e;
	logic [LEN_W-1:0] pos_next;
	logic [LEN_W-1:0] target;
	logic [LEN_W-1:0] pad_full;
	logic [31:0]      stored_next;
	logic             busy_next;
	logic             in_slot;
	cmd_t             cmd;

	assign req_stall = q_full;
	assign accept    = req_valid && !q_full;

	// first-byte checks
	always_comb begin
		lim       = (max_payload > PAYLOAD_CAP) ? PAYLOAD_CAP : max_payload;
		bad_len   = req.body_len > {{(32-LEN_W){1'b0}}, lim};
		tot_new   = HDR_LEN + ((req.body_len[LEN_W-1:0] + ALIGN_M1) & ~ALIGN_M1);
		cend_new  = HDR_LEN + req.body_len[LEN_W-1:0];
		short_buf = !req.req_type &&
			({{(31-LEN_W){1'b0}}, tot_new} > req.space_bytes);
	end

	// record state as seen by this item
	always_comb begin
		if (req.first_byte) begin
			busy_e   = !bad_len && !short_buf;
			verify_e = req.req_type;
			pos_e    = '0;
			total_e  = bad_len ? '0 : tot_new;
			cend_e   = bad_len ? '0 : cend_new;
			stored_e = '0;
		end else begin
			busy_e   = busy_q;
			verify_e = verify_q;
			pos_e    = pos_q;
			total_e  = total_q;
			cend_e   = cend_q;
			stored_e = stored_q;
		end
	end

	// classify the item
	always_comb begin
		in_slot     = pos_e < LEN_W'(SLOT_BYTES);
		pos_next    = pos_e + 1'b1;
		target      = verify_e ? total_e : cend_e;
		pad_full    = total_e - pos_next;
		stored_next = stored_e;
		if (in_slot) begin
			stored_next = stored_e | ({24'd0, req.data_byte} << {pos_e[1:0], 3'b000});
		end
		busy_next = busy_e;
		cmd       = '0;
		if (req.first_byte && bad_len) begin
			cmd.has_sum    = 1'b1;
			cmd.sum_status = ST_BAD_LEN;
		end else if (req.first_byte && short_buf) begin
			cmd.has_sum    = 1'b1;
			cmd.sum_status = ST_SHORT;
			cmd.rec_bytes  = tot_new;
		end else if (busy_e) begin
			cmd.init     = req.first_byte;
			cmd.has_byte = 1'b1;
			cmd.crc_en   = !in_slot;
			cmd.emit     = !verify_e;
			cmd.data     = in_slot ? 8'd0 : req.data_byte;
			cmd.rec_bytes = total_e;
			if (pos_next >= target) begin
				// record complete
				cmd.has_sum    = 1'b1;
				cmd.sum_calc   = 1'b1;
				cmd.sum_verify = verify_e;
				cmd.stored_crc = stored_next;
				cmd.pad_cnt    = verify_e ? '0 : pad_full[PAD_W-1:0];
				busy_next      = 1'b0;
			end else if (req.last_byte) begin
				// stream ended early
				cmd.has_sum    = 1'b1;
				cmd.sum_status = ST_SHORT;
				busy_next      = 1'b0;
			end
		end
	end

	assign push      = accept && (cmd.has_byte || cmd.has_sum);
	assign push_data = cmd;

	// record state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			verify_q <= 1'b0;
			pos_q    <= '0;
			total_q  <= '0;
			cend_q   <= '0;
			stored_q <= '0;
		end else if (accept) begin
			busy_q   <= busy_next;
			verify_q <= verify_e;
			pos_q    <= busy_e ? pos_next : pos_e;
			total_q  <= total_e;
			cend_q   <= cend_e;
			stored_q <= busy_e ? stored_next : stored_e;
		end
	end

endmodule

// ----- design/lrcf_back.sv -----
// ----------------------------------------------------------------------------
// lrcf_back: command execution and result output
// Runs the CRC-32C, emits record bytes, zero padding and summaries, one
// result per cycle into an output register while the output is not stalled.
// ----------------------------------------------------------------------------
module lrcf_back import lrcf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cmd_t      head,
	input  logic      q_empty,
	output logic      pop,
	output logic      res_valid,
	input  logic      res_stall,
	output out_item_t res
);

	logic             byte_done_q;
	logic [PAD_W-1:0] pads_done_q;
	logic [31:0]      crc_q;
	out_item_t        out_q;
	logic             out_valid_q;

	logic             room;
	logic             byte_pend;
	logic             pad_pend;
	logic             sum_pend;
	logic             byte_go;
	logic             pad_go;
	logic [31:0]      crc_base;
	logic [31:0]      crc_d;
	logic [31:0]      crc_fin;
	logic [PAD_W-1:0] pads_inc;
	logic             load;
	out_item_t        out_d;

	assign room      = !out_valid_q || !res_stall;
	assign byte_pend = !q_empty && head.has_byte && !byte_done_q;
	assign pad_pend  = !q_empty && (pads_done_q != head.pad_cnt);
	assign sum_pend  = !q_empty && head.has_sum;
	assign pads_inc  = pads_done_q + 1'b1;
	assign crc_base  = head.init ? CRC_INIT : crc_q;
	assign crc_fin   = ~crc_q;

	// pick this cycle's step: byte, then padding, then summary
	always_comb begin
		byte_go = 1'b0;
		pad_go  = 1'b0;
		pop     = 1'b0;
		crc_d   = crc_q;
		load    = 1'b0;
		out_d   = '0;
		if (byte_pend) begin
			if (!head.emit || room) begin
				byte_go = 1'b1;
				crc_d   = head.crc_en ? crc_byte(crc_base, head.data) : crc_base;
				pop     = (head.pad_cnt == '0) && !head.has_sum;
				if (head.emit) begin
					load             = 1'b1;
					out_d.out_byte   = head.data;
					out_d.byte_valid = 1'b1;
				end
			end
		end else if (pad_pend) begin
			if (room) begin
				pad_go           = 1'b1;
				crc_d            = crc_byte(crc_q, 8'd0);
				pop              = (pads_inc == head.pad_cnt) && !head.has_sum;
				load             = 1'b1;
				out_d.byte_valid = 1'b1;
			end
		end else if (sum_pend) begin
			if (room) begin
				pop                = 1'b1;
				load               = 1'b1;
				out_d.done_res     = 1'b1;
				out_d.record_bytes = head.rec_bytes;
				if (head.sum_calc) begin
					out_d.crc_value = crc_fin;
					out_d.status    = (head.sum_verify && (crc_fin != head.stored_crc)) ?
						ST_MISMATCH : ST_OK;
				end else begin
					out_d.status = head.sum_status;
				end
			end
		end
	end

	// progress through the head entry and CRC state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_done_q <= 1'b0;
			pads_done_q <= '0;
			crc_q       <= CRC_INIT;
		end else begin
			crc_q <= crc_d;
			if (pop) begin
				byte_done_q <= 1'b0;
				pads_done_q <= '0;
			end else begin
				if (byte_go) begin
					byte_done_q <= 1'b1;
				end
				if (pad_go) begin
					pads_done_q <= pads_inc;
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!res_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= out_d;
		end
	end

	assign res_valid = out_valid_q;
	assign res       = out_q;

endmodule

// ----- design/log_record_crc_framer.sv -----
// ----------------------------------------------------------------------------
// log_record_crc_framer: CRC-32C log record framer and checker
// Encodes or verifies one record per byte stream, with zero padding and a
// summary result closing each record.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+---------------------------
//  req      | in        | req_valid/req_stall  | in_item_t, one byte
//  res      | out       | res_valid/res_stall  | out_item_t, byte or summary
//  apb      | in/out    | psel/penable/pready  | max_payload at address 0
//
// One item is taken per cycle while the command queue has room. The back
// end emits one result per cycle while res_stall is low: the byte of an
// encode item, then up to seven pad bytes, then the summary. The queue
// (four entries) and the output register let input and output stall
// independently. Reset clears all control state and sets max_payload to
// 65536; no clearing pass is needed.
// ----------------------------------------------------------------------------
module log_record_crc_framer import lrcf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	// input items
	input  logic              req_valid,
	output logic              req_stall,
	input  in_item_t          req,
	// result items
	output logic              res_valid,
	input  logic              res_stall,
	output out_item_t         res,
	// configuration
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	logic [LEN_W-1:0] max_payload_q;
	logic             q_push;
	cmd_t             q_push_data;
	logic             q_pop;
	cmd_t             q_head;
	logic             q_empty;
	logic             q_full;

	// register file
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_MAX_PAYLOAD) ? {{(32-LEN_W){1'b0}}, max_payload_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q <= MAX_PAYLOAD_RST;
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_MAX_PAYLOAD)) begin
			max_payload_q <= pwdata[LEN_W-1:0];
		end
	end

	lrcf_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.max_payload (max_payload_q),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req         (req),
		.push        (q_push),
		.push_data   (q_push_data),
		.q_full      (q_full)
	);

	lrcf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_push_data),
		.pop       (q_pop),
		.head      (q_head),
		.empty     (q_empty),
		.full      (q_full)
	);

	lrcf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (q_head),
		.q_empty   (q_empty),
		.pop       (q_pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

endmodule

// ----- dv/lrcf_frame_monitor.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lrcf_frame_monitor: result predictor and comparator for the record framer
// Watches the request, result and register channels, works out the bytes
// and summaries each accepted item should produce, and compares every
// accepted result, field by field, against the oldest one still awaited.
// ----------------------------------------------------------------------------
module lrcf_frame_monitor import lrcf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  logic              req_stall,
	input  in_item_t          req,
	input  logic              res_valid,
	input  logic              res_stall,
	input  out_item_t         res,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	input  logic [31:0]       prdata,
	input  logic              pready,
	output int                fail_count,
	output int                pending,
	output int                compared
);

	localparam logic [ADDR_W-1:0] MAXP_ADDR = ADDR_W'({REG_MAX_PAYLOAD, 2'b00});
	localparam logic [31:0]       CAP32     = 32'(PAYLOAD_CAP);
	localparam logic [31:0]       ALIGN_LO  = 32'(PAD_ALIGN - 1);

	// shadow of the register and of the record in progress
	logic [LEN_W-1:0] max_len_q;
	logic             open_q;
	logic             verify_q;
	logic [LEN_W-1:0] pos_q;
	logic [LEN_W-1:0] total_q;
	logic [LEN_W-1:0] body_end_q;
	logic [31:0]      crc_q;
	logic [31:0]      slot_q;

	out_item_t awaited_items[$];
	int        mismatches;
	int        n_compared;

	// reflected CRC-32C, one byte, bit by bit
	function automatic logic [31:0] crc32c_step(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] r;
		r = c ^ {24'd0, b};
		repeat (8) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
		return r;
	endfunction

	function automatic out_item_t byte_result(input logic [7:0] b);
		out_item_t o;
		o = '0;
		o.out_byte = b;
		o.byte_valid = 1'b1;
		return o;
	endfunction

	function automatic out_item_t summary_result(input logic [1:0] st,
		input logic [LEN_W-1:0] n, input logic [31:0] c);
		out_item_t o;
		o = '0;
		o.done_res = 1'b1;
		o.status = st;
		o.record_bytes = n;
		o.crc_value = c;
		return o;
	endfunction

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		mismatches++;
		if (mismatches <= 30)
			$display("%0t mismatch %s: got %0h want %0h", $time, what, got, want);
	endtask

	// one accepted input item: update the shadow record, queue what it produces
	task automatic frame_byte(input in_item_t it);
		logic [31:0]      lim;
		logic [31:0]      tot32;
		logic [31:0]      crc_f;
		logic [7:0]       ob;
		logic [LEN_W-1:0] p;
		logic [1:0]       st;
		if (it.first_byte) begin
			lim = (32'(max_len_q) > CAP32) ? CAP32 : 32'(max_len_q);
			open_q = 1'b0;
			verify_q = it.req_type;
			pos_q = '0;
			crc_q = CRC_INIT;
			slot_q = '0;
			tot32 = 32'(HEADER_BYTES) + ((it.body_len + ALIGN_LO) & ~ALIGN_LO);
			if (it.body_len > lim) begin
				total_q = '0;
				body_end_q = '0;
				awaited_items.push_back(summary_result(ST_BAD_LEN, '0, '0));
			end else begin
				total_q = tot32[LEN_W-1:0];
				body_end_q = HDR_LEN + it.body_len[LEN_W-1:0];
				// encode needs room for the whole padded record up front
				if (!it.req_type && 32'(it.space_bytes) < tot32)
					awaited_items.push_back(summary_result(ST_SHORT, total_q, '0));
				else
					open_q = 1'b1;
			end
		end
		if (open_q) begin
			p = pos_q;
			if (verify_q) begin
				// stored checksum is little endian in the slot
				if (p < SLOT_BYTES)
					slot_q[8*p +: 8] = it.data_byte;
				else
					crc_q = crc32c_step(crc_q, it.data_byte);
			end else begin
				ob = (p < SLOT_BYTES) ? 8'd0 : it.data_byte;
				if (p >= SLOT_BYTES)
					crc_q = crc32c_step(crc_q, ob);
				awaited_items.push_back(byte_result(ob));
			end
			p = p + 1'b1;
			if (p >= (verify_q ? total_q : body_end_q)) begin
				// encode appends the zero padding right behind the last payload byte
				while (!verify_q && p < total_q) begin
					crc_q = crc32c_step(crc_q, 8'd0);
					awaited_items.push_back(byte_result(8'd0));
					p = p + 1'b1;
				end
				crc_f = ~crc_q;
				st = (verify_q && crc_f != slot_q) ? ST_MISMATCH : ST_OK;
				awaited_items.push_back(summary_result(st, total_q, crc_f));
				open_q = 1'b0;
			end else if (it.last_byte) begin
				awaited_items.push_back(summary_result(ST_SHORT, total_q, '0));
				open_q = 1'b0;
			end
			pos_q = p;
		end
	endtask

	task automatic compare_out_item(input out_item_t got);
		out_item_t want;
		if (awaited_items.size() == 0) begin
			report("result with nothing awaited, out_byte", 32'(got.out_byte), '0);
		end else begin
			want = awaited_items.pop_front();
			n_compared++;
			if (got.out_byte !== want.out_byte)
				report("out_byte", 32'(got.out_byte), 32'(want.out_byte));
			if (got.byte_valid !== want.byte_valid)
				report("byte_valid", 32'(got.byte_valid), 32'(want.byte_valid));
			if (got.done_res !== want.done_res)
				report("done_res", 32'(got.done_res), 32'(want.done_res));
			if (got.status !== want.status)
				report("status", 32'(got.status), 32'(want.status));
			if (got.record_bytes !== want.record_bytes)
				report("record_bytes", 32'(got.record_bytes), 32'(want.record_bytes));
			if (got.crc_value !== want.crc_value)
				report("crc_value", got.crc_value, want.crc_value);
		end
	endtask

	// register port first, then the item that enters, then the result that leaves
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q = MAX_PAYLOAD_RST;
			open_q = 1'b0;
			verify_q = 1'b0;
			pos_q = '0;
			total_q = '0;
			body_end_q = '0;
			crc_q = CRC_INIT;
			slot_q = '0;
			awaited_items.delete();
			mismatches = 0;
			n_compared = 0;
			fail_count <= 0;
			pending <= 0;
			compared <= 0;
		end else begin
			if (psel && penable && pready && paddr == MAXP_ADDR) begin
				if (pwrite)
					max_len_q = pwdata[LEN_W-1:0];
				else if (prdata !== 32'(max_len_q))
					report("prdata", prdata, 32'(max_len_q));
			end
			if (req_valid && !req_stall)
				frame_byte(req);
			if (res_valid && !res_stall)
				compare_out_item(res);
			fail_count <= mismatches;
			pending <= awaited_items.size();
			compared <= n_compared;
		end
	end

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: top level for the log record CRC framer
// Drives byte streams of encode and verify records, with random gaps and
// result stalls, across several max_payload settings; the frame monitor
// predicts and compares, and this top gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
	import lrcf_pkg::*;

	localparam logic [ADDR_W-1:0] MAXP_ADDR     = ADDR_W'({REG_MAX_PAYLOAD, 2'b00});
	localparam int                SETTLE_CYCLES = 48;
	localparam int                PHASE_ITEMS   = 12;
	localparam logic [31:0]       PHASE_MAX [5] = '{32'd0, 32'hFFFF_FFFF, 32'd1048576,
		32'd24, 32'd65536};

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              req_valid = 1'b0;
	logic              req_stall;
	in_item_t          req = '0;
	logic              res_valid;
	logic              res_stall = 1'b0;
	out_item_t         res;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0]       pwdata = '0;
	logic [31:0]       prdata;
	logic              pready;

	int               fail_count;
	int               pending;
	int               compared;
	int               hold_left = 0;
	int               items_sent = 0;
	int               records_sent = 0;
	int               settings_used = 0;
	bit               calm_in = 1'b0;
	bit               calm_out = 1'b0;
	logic [LEN_W-1:0] max_len = MAX_PAYLOAD_RST;

	log_record_crc_framer DUT (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.res_valid(res_valid), .res_stall(res_stall), .res(res),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	lrcf_frame_monitor frame_monitor (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.res_valid(res_valid), .res_stall(res_stall), .res(res),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.fail_count(fail_count), .pending(pending), .compared(compared)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("timeout: results still outstanding");
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic int idle_draw(input bit calm);
		return calm ? 0 : $urandom_range(6, 0);
	endfunction

	function automatic int unsigned eff_lim();
		return 32'((max_len > PAYLOAD_CAP) ? PAYLOAD_CAP : max_len);
	endfunction

	// a non-first byte with random content in every other field
	function automatic in_item_t random_item();
		in_item_t it;
		it.req_type = 1'($urandom_range(1, 0));
		it.data_byte = 8'($urandom_range(255, 0));
		it.first_byte = 1'b0;
		it.last_byte = 1'($urandom_range(1, 0));
		it.body_len = $urandom();
		it.space_bytes = 31'($urandom());
		return it;
	endfunction

	// result side: after each accepted result, stall for a drawn number of cycles
	always @(posedge clk) begin : rx_hold
		int h;
		if (res_valid && !res_stall) begin
			h = idle_draw(calm_out);
			hold_left <= h;
			res_stall <= (h != 0);
		end else if (hold_left > 1) begin
			hold_left <= hold_left - 1;
		end else begin
			hold_left <= 0;
			res_stall <= 1'b0;
		end
	end

	// valid stays up between back-to-back items; junk rides the bus while it is low
	task automatic send_item(input in_item_t it);
		int       gap;
		in_item_t junk;
		gap = idle_draw(calm_in);
		if (gap > 0) begin
			junk = random_item();
			junk.first_byte = 1'($urandom_range(1, 0));
			req_valid <= 1'b0;
			req <= junk;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= it;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		items_sent++;
	endtask

	// hold off the sender until every awaited result is out
	task automatic drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic apb_access(input bit wr, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= MAXP_ADDR;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	// new max_payload only once the block has gone quiet; read back after
	task automatic set_max(input logic [31:0] data);
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		apb_access(1'b1, data);
		apb_access(1'b0, data);
		max_len = data[LEN_W-1:0];
		settings_used++;
	endtask

	// One record of n bytes: header fields on the first, last_byte on the final
	// one when tail is set. A verify record long enough gets the right checksum
	// in its slot unless corrupt is set.
	task automatic send_record(input bit verify, input logic [31:0] plen,
		input logic [30:0] space, input int n, input bit tail, input bit corrupt);
		logic [7:0]  bytes[$];
		logic [31:0] c;
		logic [31:0] total32;
		in_item_t    it;
		total32 = 32'(HEADER_BYTES) + ((plen + 32'(PAD_ALIGN - 1)) & ~32'(PAD_ALIGN - 1));
		for (int i = 0; i < n; i++) bytes.push_back(8'($urandom_range(255, 0)));
		if (verify && !corrupt && n >= total32) begin
			c = CRC_INIT;
			for (int i = SLOT_BYTES; i < total32; i++) c = crc_byte(c, bytes[i]);
			c = ~c;
			for (int i = 0; i < SLOT_BYTES; i++) bytes[i] = c[8*i +: 8];
		end
		for (int i = 0; i < n; i++) begin
			it = random_item();
			it.data_byte = bytes[i];
			it.first_byte = (i == 0);
			it.last_byte = tail && (i == n - 1);
			if (i == 0) begin
				it.req_type = verify;
				it.body_len = plen;
				it.space_bytes = space;
			end
			send_item(it);
		end
		records_sent++;
	endtask

	// mostly complete records with small payloads; the rest cut short, abandoned,
	// rejected, or stray bytes
	task automatic random_record();
		int unsigned lim;
		int unsigned need;
		int          kind;
		bit          verify;
		logic [31:0] plen;
		logic [31:0] total;
		logic [30:0] space;
		kind = $urandom_range(99, 0);
		verify = 1'($urandom_range(1, 0));
		lim = eff_lim();
		plen = $urandom_range((lim < 20) ? lim : 20, 0);
		total = 32'(HEADER_BYTES) + ((plen + 32'(PAD_ALIGN - 1)) & ~32'(PAD_ALIGN - 1));
		need = verify ? total : HEADER_BYTES + plen;
		case ($urandom_range(3, 0))
			0: space = 31'(total);
			1: space = '1;
			default: space = 31'(total + $urandom_range(999, 0));
		endcase
		if (kind < 55) begin
			send_record(verify, plen, space,
				need + (($urandom_range(3, 0) == 0) ? $urandom_range(2, 1) : 0),
				1'($urandom_range(1, 0)), $urandom_range(4, 0) == 0);
		end else if (kind < 67) begin
			send_record(verify, plen, space, $urandom_range(need - 1, 1), 1'b1, 1'b0);
		end else if (kind < 75) begin
			// left open; the next first byte restarts
			send_record(verify, plen, space, $urandom_range(need - 1, 1), 1'b0, 1'b0);
		end else if (kind < 83) begin
			plen = $urandom_range(1, 0) ? lim + 1 + $urandom_range(30, 0)
				: ($urandom() | 32'h8000_0000);
			send_record(verify, plen, space, $urandom_range(3, 1),
				1'($urandom_range(1, 0)), 1'b0);
		end else if (kind < 90) begin
			send_record(1'b0, plen, 31'($urandom_range(total - 1, 0)), $urandom_range(3, 1),
				1'($urandom_range(1, 0)), 1'b0);
		end else if (kind < 95) begin
			repeat ($urandom_range(3, 1)) send_item(random_item());
		end else begin
			// near the limit, only the first few bytes
			plen = lim - $urandom_range((lim < 9) ? lim : 9, 0);
			send_record(verify, plen, '1, $urandom_range(6, 1), 1'b1, 1'b0);
		end
	endtask

	initial begin
		int unsigned lim;
		int          mark;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset value, stray byte, each early exit, restart
		apb_access(1'b0, '0);
		send_item(random_item());
		send_record(1'b0, 32'd65537, '1, 2, 1'b1, 1'b0);
		send_record(1'b0, 32'd65536, 31'd65559, 1, 1'b0, 1'b0);
		send_record(1'b0, 32'd65536, 31'd65560, 1, 1'b1, 1'b0);
		send_record(1'b1, 32'hFFFF_FFFF, '0, 1, 1'b0, 1'b0);
		send_record(1'b1, 32'd65536, '0, 3, 1'b1, 1'b0);
		send_record(1'b0, 32'd0, '0, 1, 1'b0, 1'b0);
		send_record(1'b0, 32'd5, '1, 2, 1'b0, 1'b0);
		send_record(1'b1, 32'd3, '1, 5, 1'b1, 1'b0);

		// random phases, one per register setting
		for (int ph = 0; ph < 5; ph++) begin
			set_max((ph == 3) ? 32'($urandom_range(64, 1)) : PHASE_MAX[ph]);
			lim = eff_lim();
			send_record(1'b0, lim + 1, '1, 1, 1'b0, 1'b0);
			send_record(1'b1, lim, '0, 2, 1'b1, 1'b0);
			mark = items_sent;
			while (items_sent - mark < PHASE_ITEMS) begin
				random_record();
				if ($urandom_range(11, 0) == 0)
					drain();
				if ($urandom_range(7, 0) == 0)
					calm_in = !calm_in;
				if ($urandom_range(7, 0) == 0)
					calm_out <= !calm_out;
			end
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("sent %0d items in %0d records over %0d max_payload settings",
			items_sent, records_sent, settings_used);
		$display("compared %0d results against the predicted stream", compared);
		if (fail_count == 0 && pending == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
